[rtl/fpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants for the framed packet parser queue.
// ----------------------------------------------------------------------------
package fpq_pkg;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] LEN_SHORT  = 8'd4;
  localparam logic [7:0] LEN_WORD   = 8'd5;
  localparam int         OPQ_DEPTH  = 4;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } fpq_phase_t;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_QUEUED = 3'd1,
    ST_CSUM   = 3'd2,
    ST_LEN    = 3'd3,
    ST_FULL   = 3'd4
  } fpq_status_t;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_DEQ      = 3'd1,
    OP_LEN_ERR  = 3'd2,
    OP_CSUM_ERR = 3'd3,
    OP_FRAME    = 3'd4
  } fpq_kind_t;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
  } fpq_in_t;

  typedef struct packed {
    logic        entry_valid;
    logic [7:0]  entry_cmd;
    logic [7:0]  entry_id;
    logic [15:0] entry_value;
    fpq_status_t frame_status;
    logic [3:0]  queue_count;
  } fpq_out_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  id;
    logic [7:0]  cmd;
  } fpq_entry_t;

  typedef struct packed {
    fpq_kind_t  kind;
    fpq_entry_t frame;
  } fpq_op_t;

endpackage

[rtl/fpq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_in_if / fpq_out_if
// Valid/ready channels for requests into and results out of the parser queue.
// ----------------------------------------------------------------------------
interface fpq_in_if
  import fpq_pkg::*;
;
  logic    valid;
  logic    ready;
  fpq_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fpq_out_if
  import fpq_pkg::*;
;
  logic     valid;
  logic     ready;
  fpq_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/fpq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_front
// Frame parser: hunts for the start byte, tracks length and checksum, and
// classifies each request into one operation for the back end.
// ----------------------------------------------------------------------------
module fpq_front
  import fpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  fpq_in_t item,
  output fpq_op_t op
);

  fpq_phase_t phase, phase_next;
  logic [7:0] frame_len, frame_len_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_cmd, held_cmd_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_low, held_low_next;
  logic [7:0] held_high, held_high_next;
  logic [8:0] seen_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      frame_len   <= '0;
      bytes_seen  <= '0;
      running_sum <= '0;
      held_cmd    <= '0;
      held_id     <= '0;
      held_low    <= '0;
      held_high   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      frame_len   <= frame_len_next;
      bytes_seen  <= bytes_seen_next;
      running_sum <= running_sum_next;
      held_cmd    <= held_cmd_next;
      held_id     <= held_id_next;
      held_low    <= held_low_next;
      held_high   <= held_high_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    frame_len_next   = frame_len;
    bytes_seen_next  = bytes_seen;
    running_sum_next = running_sum;
    held_cmd_next    = held_cmd;
    held_id_next     = held_id;
    held_low_next    = held_low;
    held_high_next   = held_high;
    seen_inc         = {1'b0, bytes_seen} + 9'd1;
    op.kind          = OP_NONE;
    op.frame         = '0;
    if (item.command) begin
      op.kind = OP_DEQ;
    end else begin
      case (phase)
        PH_LEN: begin
          frame_len_next   = item.byte_in;
          bytes_seen_next  = '0;
          running_sum_next = '0;
          phase_next       = PH_BODY;
        end
        PH_BODY: begin
          case (bytes_seen)
            8'd0:    held_cmd_next  = item.byte_in;
            8'd1:    held_id_next   = item.byte_in;
            8'd2:    held_low_next  = item.byte_in;
            8'd3:    held_high_next = item.byte_in;
            default: ;
          endcase
          running_sum_next = running_sum + item.byte_in;
          bytes_seen_next  = seen_inc[7:0];
          if (seen_inc >= {1'b0, frame_len}) begin
            phase_next = PH_HUNT;
            if (frame_len < LEN_SHORT) begin
              op.kind = OP_LEN_ERR;
            end else if (running_sum_next != 8'd0) begin
              op.kind = OP_CSUM_ERR;
            end else begin
              op.kind = OP_FRAME;
            end
            op.frame.cmd = held_cmd_next;
            op.frame.id  = held_id_next;
            if (frame_len == LEN_SHORT) begin
              op.frame.value = {8'd0, held_low_next};
            end else if (frame_len == LEN_WORD) begin
              op.frame.value = {held_high_next, held_low_next};
            end
          end
        end
        default: begin
          phase_next = (item.byte_in == START_BYTE) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

endmodule

[rtl/fpq_op_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_op_fifo
// Short queue of classified operations between the parser and the frame queue.
// ----------------------------------------------------------------------------
module fpq_op_fifo
  import fpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  fpq_op_t push_op,
  input  logic    pop,
  output fpq_op_t pop_op,
  output logic    empty,
  output logic    full,
  output logic [$clog2(OPQ_DEPTH):0] level
);

  localparam int PW = $clog2(OPQ_DEPTH);

  fpq_op_t       slots [OPQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign empty  = (level == '0);
  assign full   = (level == (PW+1)'(OPQ_DEPTH));
  assign pop_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + (PW+1)'(1);
      end else if (pop && !push) begin
        level <= level - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

[rtl/fpq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpq_back
// Frame ring queue: stores good frames, serves dequeues, and registers the
// result of each operation.
// ----------------------------------------------------------------------------
module fpq_back
  import fpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  input  fpq_op_t  op,
  output logic     op_take,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output fpq_out_t rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH);

  fpq_entry_t     store [QUEUE_DEPTH];
  logic [CW-1:0]  head, head_next;
  logic [CW-1:0]  tail, tail_next;
  logic [CW-1:0]  count, count_next;
  logic           wr_en;
  logic           rd_en;
  logic           hit, hit_next;
  fpq_status_t    status, status_next;
  fpq_entry_t     rd_data;
  logic [CW+3:0]  count_ext;

  assign op_take = op_valid && (!rsp_valid || rsp_ready);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    hit_next    = 1'b0;
    status_next = ST_NONE;
    case (op.kind)
      OP_DEQ: begin
        if (count != '0) begin
          rd_en      = 1'b1;
          hit_next   = 1'b1;
          head_next  = (head == CW'(QUEUE_DEPTH - 1)) ? '0 : head + CW'(1);
          count_next = count - CW'(1);
        end
      end
      OP_LEN_ERR:  status_next = ST_LEN;
      OP_CSUM_ERR: status_next = ST_CSUM;
      OP_FRAME: begin
        if (count == CW'(QUEUE_DEPTH - 1)) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_QUEUED;
          wr_en       = 1'b1;
          tail_next   = (tail == CW'(QUEUE_DEPTH - 1)) ? '0 : tail + CW'(1);
          count_next  = count + CW'(1);
        end
      end
      default: status_next = ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else if (op_take) begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      hit    <= hit_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && wr_en) begin
      store[tail] <= op.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && rd_en) begin
      rd_data <= store[head];
    end
  end

  assign count_ext = (CW+4)'(count);

  always_comb begin
    rsp.entry_valid  = hit;
    rsp.entry_cmd    = hit ? rd_data.cmd : 8'd0;
    rsp.entry_id     = hit ? rd_data.id : 8'd0;
    rsp.entry_value  = hit ? rd_data.value : 16'd0;
    rsp.frame_status = status;
    rsp.queue_count  = count_ext[3:0];
  end

endmodule

[rtl/framed_packet_parser_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_parser_queue_core
// Serial frame parser with checksum check feeding a ring queue of frames.
//
//   channel   dir   payload
//   req       in    command, byte_in
//   rsp       out   entry_valid, entry_cmd, entry_id, entry_value,
//                   frame_status, queue_count
//
// One request per cycle while results are taken. Each accepted request is
// queued as an operation; the frame queue then registers result and store read.
// The parser and the queue are joined by a four-entry operation queue, so a
// stalled result port holds the frame queue while the parser takes up to four
// more requests; past that, req.ready drops until the result is taken.
// Synchronous reset empties the frame queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module framed_packet_parser_queue_core
  import fpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  fpq_in_if.sink    req,
  fpq_out_if.source rsp
);

  logic                      accept;
  fpq_op_t                   new_op;
  fpq_op_t                   head_op;
  logic                      opq_empty;
  logic                      opq_full;
  logic                      op_take;
  logic [$clog2(OPQ_DEPTH):0] opq_level;

  assign req.ready = !opq_full;
  assign accept    = req.valid && req.ready;

  fpq_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (req.payload),
    .op     (new_op)
  );

  fpq_op_fifo u_opq (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .push_op (new_op),
    .pop     (op_take),
    .pop_op  (head_op),
    .empty   (opq_empty),
    .full    (opq_full),
    .level   (opq_level)
  );

  fpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (!opq_empty),
    .op        (head_op),
    .op_take   (op_take),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp       (rsp.payload)
  );

`ifndef SYNTHESIS
  a_accept_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    accept |=> !opq_empty)
    else $error("accepted request missing from operation queue");

  a_opq_bound: assert property (@(posedge clk) disable iff (rst)
    opq_level <= ($clog2(OPQ_DEPTH)+1)'(OPQ_DEPTH))
    else $error("operation queue overfilled");

  a_deq_no_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.entry_valid) |-> (rsp.payload.frame_status == ST_NONE))
    else $error("dequeue result carries a frame status");
`endif

endmodule

[dv/framed_packet_parser_queue_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_parser_queue_core_tb
// Feeds serial bytes and dequeue requests into the parser queue and checks
// every result against table values or an in-bench parser and queue model.
// A directed table comes first: zero length, both payload sizes, a checksum
// error and dequeues on an empty and a loaded queue. Random framed traffic
// follows. Its bursts are chosen to fill the queue to overflow, to drain it
// empty, or to mix both. Both channels idle at random, and the result side
// holds off for long stretches so that the core backs up and stalls requests.
// ----------------------------------------------------------------------------
module framed_packet_parser_queue_core_tb
  import fpq_pkg::*;
;

  localparam int   DEPTH        = 16;
  localparam logic CMD_PUSH     = 1'b0;
  localparam logic CMD_DEQ      = 1'b1;
  localparam int   RAND_ITEMS   = 700;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   DRAIN_CYCLES = 10;

  typedef struct {
    fpq_in_t  rq;
    bit       typed;
    fpq_out_t res;
  } dir_row_t;

  typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} deq_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpq_in_if  req_ch ();
  fpq_out_if rsp_ch ();

  framed_packet_parser_queue_core #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  fpq_phase_t prs_phase;
  logic [7:0] prs_len;
  logic [7:0] prs_seen;
  logic [7:0] prs_sum;
  logic [7:0] hold_cmd;
  logic [7:0] hold_id;
  logic [7:0] hold_low;
  logic [7:0] hold_high;
  fpq_entry_t frame_mem [DEPTH];
  logic [3:0] q_head;
  logic [3:0] q_tail;

  fpq_out_t    pending_results [$];
  dir_row_t    dir_rows [$];
  fpq_in_t     rand_reqs [$];
  fpq_out_t    due;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  bit          req_steady = 1'b0;

  always #5 clk = ~clk;

  function automatic fpq_out_t frame_queue_step(fpq_in_t rq);
    fpq_out_t    o;
    fpq_entry_t  e;
    int unsigned seen_n;
    o = '0;
    o.frame_status = ST_NONE;
    if (rq.command == CMD_DEQ) begin
      if (q_tail != q_head) begin
        e = frame_mem[q_head];
        o.entry_valid = 1'b1;
        o.entry_cmd = e.cmd;
        o.entry_id = e.id;
        o.entry_value = e.value;
        q_head = q_head + 4'd1;
      end
    end else begin
      case (prs_phase)
        PH_LEN: begin
          prs_len = rq.byte_in;
          prs_seen = '0;
          prs_sum = '0;
          prs_phase = PH_BODY;
        end
        PH_BODY: begin
          case (prs_seen)
            8'd0: hold_cmd = rq.byte_in;
            8'd1: hold_id = rq.byte_in;
            8'd2: hold_low = rq.byte_in;
            8'd3: hold_high = rq.byte_in;
            default: ;
          endcase
          prs_sum = prs_sum + rq.byte_in;
          seen_n = prs_seen + 1;
          if (seen_n >= prs_len) begin
            if (prs_len < LEN_SHORT) begin
              o.frame_status = ST_LEN;
            end else if (prs_sum != 8'd0) begin
              o.frame_status = ST_CSUM;
            end else if (4'(q_tail - q_head) == 4'(DEPTH - 1)) begin
              o.frame_status = ST_FULL;
            end else begin
              e.cmd = hold_cmd;
              e.id = hold_id;
              if (prs_len == LEN_SHORT) e.value = {8'h00, hold_low};
              else if (prs_len == LEN_WORD) e.value = {hold_high, hold_low};
              else e.value = '0;
              frame_mem[q_tail] = e;
              q_tail = q_tail + 4'd1;
              o.frame_status = ST_QUEUED;
            end
            prs_phase = PH_HUNT;
          end
          prs_seen = seen_n[7:0];
        end
        default: prs_phase = (rq.byte_in == START_BYTE) ? PH_LEN : PH_HUNT;
      endcase
    end
    o.queue_count = q_tail - q_head;
    return o;
  endfunction

  function automatic fpq_out_t outcome(logic v, logic [7:0] c, logic [7:0] id,
                                       logic [15:0] val, fpq_status_t st,
                                       logic [3:0] cnt);
    return fpq_out_t'{v, c, id, val, st, cnt};
  endfunction

  function automatic void add_row(logic c, logic [7:0] b, bit typed = 1'b0,
                                  fpq_out_t res = '0);
    dir_rows.push_back('{fpq_in_t'{c, b}, typed, res});
  endfunction

  task automatic build_random_stream();
    int unsigned frames;
    int unsigned len;
    int unsigned nbody;
    int unsigned ndeq;
    int unsigned k;
    logic [7:0]  sum;
    logic [7:0]  b;
    deq_mode_t   mode;
    bit          good;
    frames = 0;
    mode = MODE_FILL;
    while (rand_reqs.size() < RAND_ITEMS) begin
      if (frames != 0 && frames % 20 == 0) mode = deq_mode_t'($urandom_range(0, 2));
      case (mode)
        MODE_FILL: ndeq = 0;
        MODE_MIX:  ndeq = $urandom_range(0, 2);
        default:   ndeq = $urandom_range(1, 4);
      endcase
      repeat (ndeq) rand_reqs.push_back(fpq_in_t'{CMD_DEQ, 8'($urandom)});
      if ($urandom_range(0, 99) < 25)
        repeat ($urandom_range(1, 3)) rand_reqs.push_back(fpq_in_t'{CMD_PUSH, 8'($urandom)});
      k = $urandom_range(0, 99);
      if (frames == 40) len = 255;
      else if (k < 60) len = $urandom_range(4, 5);
      else if (k < 75) len = $urandom_range(0, 3);
      else if (k < 95) len = $urandom_range(6, 12);
      else len = $urandom_range(13, 40);
      good = $urandom_range(0, 99) < 85;
      nbody = (len == 0) ? 1 : len;
      rand_reqs.push_back(fpq_in_t'{CMD_PUSH, START_BYTE});
      rand_reqs.push_back(fpq_in_t'{CMD_PUSH, 8'(len)});
      sum = '0;
      for (int i = 0; i < nbody; i++) begin
        if (mode != MODE_FILL && $urandom_range(0, 99) < 5)
          rand_reqs.push_back(fpq_in_t'{CMD_DEQ, 8'($urandom)});
        b = 8'($urandom);
        if (i == nbody - 1 && good) b = -sum;
        sum = sum + b;
        rand_reqs.push_back(fpq_in_t'{CMD_PUSH, b});
      end
      frames++;
    end
  endtask

  task automatic offer_request(fpq_in_t rq, bit typed, fpq_out_t fixed);
    int unsigned gap;
    fpq_out_t    pred;
    if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
    gap = req_steady ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= rq;
    do @(posedge clk); while (!req_ch.ready);
    pred = frame_queue_step(rq);
    pending_results.push_back(typed ? fixed : pred);
  endtask

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %p", $time, rsp_ch.payload);
      end else begin
        due = pending_results.pop_front();
        cmp_field("entry_valid", due.entry_valid, rsp_ch.payload.entry_valid);
        cmp_field("entry_cmd", due.entry_cmd, rsp_ch.payload.entry_cmd);
        cmp_field("entry_id", due.entry_id, rsp_ch.payload.entry_id);
        cmp_field("entry_value", due.entry_value, rsp_ch.payload.entry_value);
        cmp_field("frame_status", due.frame_status, rsp_ch.payload.frame_status);
        cmp_field("queue_count", due.queue_count, rsp_ch.payload.queue_count);
      end
    end
  end

  initial begin
    int unsigned gap;
    int unsigned hold_at;
    bit          steady;
    rsp_ch.ready = 1'b0;
    hold_at = 150;
    steady = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      // hold off long enough for the core to back up into the request side
      if (results_seen >= hold_at) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_at = hold_at + 350;
      end
      if ($urandom_range(0, 39) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    prs_phase = PH_HUNT;
    prs_len = '0;
    prs_seen = '0;
    prs_sum = '0;
    hold_cmd = '0;
    hold_id = '0;
    hold_low = '0;
    hold_high = '0;
    q_head = '0;
    q_tail = '0;

    add_row(CMD_DEQ, 8'h00, 1'b1, outcome(1'b0, 8'h00, 8'h00, 16'h0000, ST_NONE, 4'd0));
    add_row(CMD_PUSH, START_BYTE);
    add_row(CMD_PUSH, 8'h00);
    add_row(CMD_PUSH, 8'hFF, 1'b1, outcome(1'b0, 8'h00, 8'h00, 16'h0000, ST_LEN, 4'd0));
    add_row(CMD_PUSH, START_BYTE);
    add_row(CMD_PUSH, LEN_SHORT);
    add_row(CMD_PUSH, 8'h12);
    add_row(CMD_PUSH, 8'h34);
    add_row(CMD_PUSH, 8'h56);
    add_row(CMD_PUSH, 8'h64, 1'b1, outcome(1'b0, 8'h00, 8'h00, 16'h0000, ST_QUEUED, 4'd1));
    add_row(CMD_PUSH, START_BYTE);
    add_row(CMD_PUSH, LEN_WORD);
    add_row(CMD_PUSH, 8'hFF);
    add_row(CMD_PUSH, 8'hFF);
    add_row(CMD_PUSH, 8'hFF);
    add_row(CMD_PUSH, 8'hFF);
    add_row(CMD_PUSH, 8'h04, 1'b1, outcome(1'b0, 8'h00, 8'h00, 16'h0000, ST_QUEUED, 4'd2));
    add_row(CMD_PUSH, START_BYTE);
    add_row(CMD_PUSH, LEN_SHORT);
    add_row(CMD_PUSH, 8'h01);
    add_row(CMD_PUSH, 8'h02);
    add_row(CMD_PUSH, 8'h03);
    add_row(CMD_PUSH, 8'h00, 1'b1, outcome(1'b0, 8'h00, 8'h00, 16'h0000, ST_CSUM, 4'd2));
    add_row(CMD_DEQ, 8'hFF, 1'b1, outcome(1'b1, 8'h12, 8'h34, 16'h0056, ST_NONE, 4'd1));
    add_row(CMD_DEQ, 8'h00, 1'b1, outcome(1'b1, 8'hFF, 8'hFF, 16'hFFFF, ST_NONE, 4'd0));
    build_random_stream();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);
    foreach (rand_reqs[i]) offer_request(rand_reqs[i], 1'b0, '0);
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
